// ===== hw/rtl/box_muller_gaussian_pair_unit_macros.svh =====
// Assertion macros for the Gaussian pair unit.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef BOX_MULLER_GAUSSIAN_PAIR_UNIT_MACROS_SVH
`define BOX_MULLER_GAUSSIAN_PAIR_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define BM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication, checked out of reset
`define BM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== hw/rtl/bm_pkg.sv =====
// Package for the Gaussian pair unit: sizes, fixed-point constants,
// pipeline word types and the divide-by-constant helper. No dependencies.
package bm_pkg;

    localparam int UNIFORM_BITS_DEF = 32;
    localparam int UNI_W            = 32;
    localparam int LOG_FRAC         = 28;
    localparam int LOG_CELLS        = LOG_FRAC;
    localparam int SQRT_TOP         = 44;
    localparam int SQRT_CELLS       = SQRT_TOP / 2 + 1;
    localparam int TRIG_STAGES      = 8;
    localparam int EMIT_STAGES      = 2;
    localparam int CFG_IDX_W        = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MEAN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD = 1'b1;

    localparam logic [30:0] TRIG_ONE       = 31'h4000_0000;
    localparam logic [30:0] TWO_LN2_Q30    = 31'd1488522236;
    localparam logic [31:0] QUARTER_PI_Q32 = 32'd3373259426;
    localparam logic [30:0] SPREAD_RESET   = 31'd65536;

    localparam logic [30:0] RCP_42 = 31'((64'd1 << 33) / 64'd42);
    localparam logic [30:0] RCP_56 = 31'((64'd1 << 33) / 64'd56);
    localparam logic [30:0] RCP_20 = 31'((64'd1 << 33) / 64'd20);
    localparam logic [30:0] RCP_30 = 31'((64'd1 << 33) / 64'd30);
    localparam logic [30:0] RCP_6  = 31'((64'd1 << 33) / 64'd6);
    localparam logic [30:0] RCP_12 = 31'((64'd1 << 33) / 64'd12);

    typedef struct packed {
        logic [31:0] m;
        logic [LOG_FRAC-1:0] frac;
        logic [4:0]  e;
        logic        inf;
        logic [29:0] x;
        logic [2:0]  oct;
    } t_log_word;

    typedef struct packed {
        logic [45:0] v;
        logic [46:0] res;
        logic        inf;
        logic [29:0] x;
        logic [2:0]  oct;
    } t_sqrt_word;

    typedef struct packed {
        logic [30:0] sv;
        logic [30:0] cv;
        logic        neg_s;
        logic        neg_c;
        logic        inf;
        logic [23:0] r;
    } t_trig_word;

    // floor(num / dvs) by reciprocal multiply and one correction step
    function automatic logic [30:0] div_const(input logic [30:0] num,
                                              input logic [30:0] rcp,
                                              input logic [5:0]  dvs);
        logic [61:0] prod;
        logic [30:0] q;
        logic [30:0] back;
        logic [30:0] rem;
        prod = 62'(num) * 62'(rcp);
        q    = 31'(prod[61:33]);
        back = 31'(37'(q) * 37'(dvs));
        rem  = num - back;
        if (rem >= 31'(dvs)) begin
            q = q + 31'd1;
        end
        return q;
    endfunction

endpackage

// ===== hw/rtl/bm_if.sv =====
// Channel interfaces of the Gaussian pair unit: input, result, config.
// Depends on bm_pkg.
interface bm_in_if import bm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [UNI_W-1:0] uniform_radius;
    logic [UNI_W-1:0] uniform_angle;
    modport source(output valid, uniform_radius, uniform_angle, input ready);
    modport sink(input valid, uniform_radius, uniform_angle, output ready);
endinterface

interface bm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] normal_sine;
    logic [31:0] normal_cosine;
    logic        saturated;
    modport source(output valid, normal_sine, normal_cosine, saturated, input ready);
    modport sink(input valid, normal_sine, normal_cosine, saturated, output ready);
endinterface

interface bm_cfg_if import bm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/box_muller_gaussian_pair_unit.sv =====
// Top level of the Box-Muller Gaussian pair unit.
// Depends on bm_pkg, bm_if, bm_log_cell, bm_sqrt_cell, bm_trig, bm_emit
// and box_muller_gaussian_pair_unit_macros.svh.
//
//  channel  direction  words carried
//  i_in     in         uniform_radius, uniform_angle (32 bit codes)
//  o_out    out        normal_sine, normal_cosine (Q16.16), saturated
//  i_cfg    in         index 0 mean_offset, index 1 spread_scale
//
// One word per cycle is taken while the chain advances. The stages are one front stage,
// 28 log cells, one scaling stage, 23 square-root cells, eight trig stages, two scaling
// stages and the output register. The chain of cells sets the latency. Reset is
// synchronous, active low; it clears valid flags and mean, sets spread to 65536.
// A stalled output holds; the chain keeps moving while its last stage is empty,
// so bubbles close up and input is taken while a result waits.
`include "box_muller_gaussian_pair_unit_macros.svh"

module box_muller_gaussian_pair_unit import bm_pkg::*; #(
    parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bm_in_if.sink     i_in,
    bm_out_if.source  o_out,
    bm_cfg_if.sink    i_cfg
);
    localparam int KeepBits = (UNIFORM_BITS > UNI_W) ? UNI_W : UNIFORM_BITS;
    localparam logic [UNI_W-1:0] KeepMask = {UNI_W{1'b1}} << (UNI_W - KeepBits);
    localparam int NStage = 2 + LOG_CELLS + SQRT_CELLS + TRIG_STAGES + EMIT_STAGES;
    localparam int Last   = NStage - 1;

    // configuration registers
    logic signed [31:0] r_mean;
    logic [30:0]        r_spread;

    // valid flags of the chain and the output register
    logic [NStage-1:0] r_vld;
    logic              r_out_vld;
    logic [31:0]       r_out_sine;
    logic [31:0]       r_out_cos;
    logic              r_out_sat;
    logic              w_en;

    // front stage signals
    logic [UNI_W-1:0] c1, c2;
    logic [4:0]       lead;
    logic [29:0]      phi;
    logic [61:0]      xprod;
    t_log_word        n_front;
    t_log_word        r_front;

    // scaling stage signals
    logic [33:0]  tval;
    logic [64:0]  sprod;
    t_sqrt_word   n_scale;
    t_sqrt_word   r_scale;

    t_log_word  w_log  [LOG_CELLS+1];
    t_sqrt_word w_sqrt [SQRT_CELLS+1];
    t_trig_word w_trig;
    logic [31:0] w_sine, w_cos;
    logic        w_flag_s, w_flag_c;

    // advance while the output can take a word or the tail holds a bubble
    assign w_en       = !r_out_vld || o_out.ready || !r_vld[Last];
    assign i_in.ready = w_en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean   <= '0;
            r_spread <= SPREAD_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_MEAN: begin
                    r_mean <= i_cfg.data;
                end
                CFG_SPREAD: begin
                    r_spread <= i_cfg.data[30:0];
                end
                default: begin
                end
            endcase
        end
    end

    // front: drop unused low bits, normalize radius code, map angle to octant
    always_comb begin
        c1   = i_in.uniform_radius & KeepMask;
        c2   = i_in.uniform_angle & KeepMask;
        lead = '0;
        for (int k = 0; k < UNI_W; k++) begin
            if (c1[k]) begin
                lead = 5'(k);
            end
        end
        phi = c2[29] ? (30'h2000_0000 - {1'b0, c2[28:0]}) : {1'b0, c2[28:0]};
        xprod = 62'(phi) * 62'(QUARTER_PI_Q32);
        n_front.m    = c1 << (5'd31 - lead);
        n_front.frac = '0;
        n_front.e    = lead;
        n_front.inf  = (c1 == '0);
        n_front.x    = xprod[60:31];
        n_front.oct  = c2[31:29];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_front <= n_front;
        end
    end

    assign w_log[0] = r_front;

    for (genvar g = 0; g < LOG_CELLS; g++) begin : g_log
        bm_log_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_word (w_log[g]),
            .o_word (w_log[g+1])
        );
    end

    // scale: t = 32 - e - log2(x), s = t * 2ln2 in Q.40
    always_comb begin
        tval  = (34'(6'd32 - {1'b0, w_log[LOG_CELLS].e}) << LOG_FRAC)
              - 34'(w_log[LOG_CELLS].frac);
        sprod = 65'(tval) * 65'(TWO_LN2_Q30);
        n_scale.v   = sprod[63:18];
        n_scale.res = '0;
        n_scale.inf = w_log[LOG_CELLS].inf;
        n_scale.x   = w_log[LOG_CELLS].x;
        n_scale.oct = w_log[LOG_CELLS].oct;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_scale <= n_scale;
        end
    end

    assign w_sqrt[0] = r_scale;

    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
        bm_sqrt_cell #(.INDEX(g)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_word (w_sqrt[g]),
            .o_word (w_sqrt[g+1])
        );
    end

    bm_trig u_trig (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (w_sqrt[SQRT_CELLS].x),
        .i_oct  (w_sqrt[SQRT_CELLS].oct),
        .i_inf  (w_sqrt[SQRT_CELLS].inf),
        .i_r    (w_sqrt[SQRT_CELLS].res[23:0]),
        .o_trig (w_trig)
    );

    bm_emit u_emit_sine (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_trig   (w_trig.sv),
        .i_neg    (w_trig.neg_s),
        .i_inf    (w_trig.inf),
        .i_r      (w_trig.r),
        .i_mean   (r_mean),
        .i_spread (r_spread),
        .o_value  (w_sine),
        .o_flag   (w_flag_s)
    );

    bm_emit u_emit_cos (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_trig   (w_trig.cv),
        .i_neg    (w_trig.neg_c),
        .i_inf    (w_trig.inf),
        .i_r      (w_trig.r),
        .i_mean   (r_mean),
        .i_spread (r_spread),
        .o_value  (w_cos),
        .o_flag   (w_flag_c)
    );

    // valid flags follow the words down the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[NStage-2:0], i_in.valid};
            end
            if (w_en && r_vld[Last]) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // output register: load the finished word, hold it while stalled
    always_ff @(posedge i_clk) begin
        if (w_en && r_vld[Last]) begin
            r_out_sine <= w_sine;
            r_out_cos  <= w_cos;
            r_out_sat  <= w_flag_s || w_flag_c;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.normal_sine   = r_out_sine;
    assign o_out.normal_cosine = r_out_cos;
    assign o_out.saturated     = r_out_sat;

    `BM_ASSERT_NOW(a_bubble_moves, !r_vld[Last], w_en && i_in.ready)
    `BM_ASSERT_NEXT(a_tail_lands, w_en && r_vld[Last], r_out_vld)
    `BM_ASSERT_NOW(a_stall_full, !w_en, r_out_vld && r_vld[Last] && !o_out.ready)
endmodule

// ===== hw/rtl/bm_log_cell.sv =====
// One log2 fraction cell: square the mantissa, emit one fraction bit.
// Depends on bm_pkg.
module bm_log_cell import bm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_log_word i_word,
    output t_log_word o_word
);
    logic [63:0] sq;
    logic [32:0] p;
    t_log_word   n_word;
    t_log_word   r_word;

    always_comb begin
        sq     = 64'(i_word.m) * 64'(i_word.m);
        p      = sq[63:31];
        n_word = i_word;
        n_word.frac = {i_word.frac[LOG_FRAC-2:0], p[32]};
        // renormalize to [1,2) when the square reached 2
        n_word.m    = p[32] ? p[32:1] : p[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;
endmodule

// ===== hw/rtl/bm_sqrt_cell.sv =====
// One restoring square-root cell: try one result bit, subtract if it fits.
// Depends on bm_pkg.
module bm_sqrt_cell import bm_pkg::*; #(
    parameter int INDEX = 0
) (
    input  logic       i_clk,
    input  logic       i_en,
    input  t_sqrt_word i_word,
    output t_sqrt_word o_word
);
    localparam int          Shift = SQRT_TOP - 2 * INDEX;
    localparam logic [46:0] Bit   = 47'(1) << Shift;

    logic [46:0] trial;
    t_sqrt_word  n_word;
    t_sqrt_word  r_word;

    always_comb begin
        trial  = i_word.res + Bit;
        n_word = i_word;
        if ({1'b0, i_word.v} >= trial) begin
            n_word.v   = 46'({1'b0, i_word.v} - trial);
            n_word.res = (i_word.res >> 1) + Bit;
        end else begin
            n_word.res = i_word.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;
endmodule

// ===== hw/rtl/bm_trig.sv =====
// Sine and cosine over one octant by Horner-form Taylor series, eight stages,
// then octant swap and signs. Depends on bm_pkg.
module bm_trig import bm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [29:0] i_x,
    input  logic [2:0]  i_oct,
    input  logic        i_inf,
    input  logic [23:0] i_r,
    output t_trig_word  o_trig
);
    typedef struct packed {
        logic [29:0] x;
        logic [29:0] z;
        logic [2:0]  oct;
        logic        inf;
        logic [23:0] r;
    } t_side;

    function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] prod;
        prod = 62'(a) * 62'(b);
        return prod[60:30];
    endfunction

    t_side       r_side [TRIG_STAGES-1];
    logic [30:0] r_ta, r_ua, r_ps3, r_pc3, r_tb, r_ub, r_ps5, r_pc5, r_tc, r_uc;
    logic [30:0] r_sn, r_pc7;
    t_trig_word  r_trig;
    t_trig_word  n_trig;
    t_side       n_side0;
    logic [59:0] zprod;
    logic [30:0] cs;
    logic [3:0]  oct_p1;
    logic [3:0]  oct_p2;

    always_comb begin
        zprod       = 60'(i_x) * 60'(i_x);
        n_side0.x   = i_x;
        n_side0.z   = zprod[59:30];
        n_side0.oct = i_oct;
        n_side0.inf = i_inf;
        n_side0.r   = i_r;
    end

    always_comb begin
        cs     = TRIG_ONE - (r_pc7 >> 1);
        oct_p1 = {1'b0, r_side[TRIG_STAGES-2].oct} + 4'd1;
        oct_p2 = {1'b0, r_side[TRIG_STAGES-2].oct} + 4'd2;
        // odd-ish octants trade sine and cosine
        n_trig.sv    = oct_p1[1] ? cs : r_sn;
        n_trig.cv    = oct_p1[1] ? r_sn : cs;
        n_trig.neg_s = r_side[TRIG_STAGES-2].oct[2];
        n_trig.neg_c = oct_p2[2];
        n_trig.inf   = r_side[TRIG_STAGES-2].inf;
        n_trig.r     = r_side[TRIG_STAGES-2].r;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= n_side0;
            for (int k = 1; k < TRIG_STAGES - 1; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_ta  <= TRIG_ONE - div_const({1'b0, r_side[0].z}, RCP_42, 6'd42);
            r_ua  <= TRIG_ONE - div_const({1'b0, r_side[0].z}, RCP_56, 6'd56);
            r_ps3 <= mul_q30({1'b0, r_side[1].z}, r_ta);
            r_pc3 <= mul_q30({1'b0, r_side[1].z}, r_ua);
            r_tb  <= TRIG_ONE - div_const(r_ps3, RCP_20, 6'd20);
            r_ub  <= TRIG_ONE - div_const(r_pc3, RCP_30, 6'd30);
            r_ps5 <= mul_q30({1'b0, r_side[3].z}, r_tb);
            r_pc5 <= mul_q30({1'b0, r_side[3].z}, r_ub);
            r_tc  <= TRIG_ONE - div_const(r_ps5, RCP_6, 6'd6);
            r_uc  <= TRIG_ONE - div_const(r_pc5, RCP_12, 6'd12);
            r_sn  <= mul_q30({1'b0, r_side[5].x}, r_tc);
            r_pc7 <= mul_q30({1'b0, r_side[5].z}, r_uc);
            r_trig <= n_trig;
        end
    end

    assign o_trig = r_trig;
endmodule

// ===== hw/rtl/bm_emit.sv =====
// One output lane: scale radius by trig and sigma over two stages, then add
// the mean and clamp. Depends on bm_pkg.
module bm_emit import bm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [30:0]        i_trig,
    input  logic               i_neg,
    input  logic               i_inf,
    input  logic [23:0]        i_r,
    input  logic signed [31:0] i_mean,
    input  logic [30:0]        i_spread,
    output logic [31:0]        o_value,
    output logic               o_flag
);
    localparam logic signed [36:0] Max = 37'sd2147483647;
    localparam logic signed [36:0] Min = -37'sd2147483648;

    logic [54:0]        prod1;
    logic [54:0]        prod2;
    logic [23:0]        r1_m;
    logic               r1_neg, r1_inf, r1_tz;
    logic [34:0]        r2_mag;
    logic               r2_neg, r2_inf, r2_tz;
    logic signed [36:0] smag;
    logic signed [36:0] sum;

    always_comb begin
        prod1 = 55'(i_r) * 55'(i_trig);
        prod2 = 55'(i_spread) * 55'(r1_m);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_m   <= prod1[53:30];
            r1_neg <= i_neg;
            r1_inf <= i_inf;
            r1_tz  <= (i_trig == 31'd0);
            r2_mag <= prod2[54:20];
            r2_neg <= r1_neg;
            r2_inf <= r1_inf;
            r2_tz  <= r1_tz;
        end
    end

    always_comb begin
        smag    = r2_neg ? -$signed({2'b00, r2_mag}) : $signed({2'b00, r2_mag});
        sum     = 37'(i_mean) + smag;
        o_flag  = r2_inf;
        o_value = 32'(sum);
        if (r2_inf) begin
            // infinite radius: mean where the product vanishes, else the rail
            if (r2_tz || i_spread == 31'd0) begin
                o_value = i_mean;
            end else begin
                o_value = r2_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
        end else if (sum > Max) begin
            o_value = 32'h7FFF_FFFF;
            o_flag  = 1'b1;
        end else if (sum < Min) begin
            o_value = 32'h8000_0000;
            o_flag  = 1'b1;
        end
    end
endmodule

// ===== tb/bm_tb_pkg.sv =====
// Test-side package for the Gaussian pair unit: the fixed-point predictor.
// Self-contained: it does not import bm_pkg.
package bm_tb_pkg;

    typedef struct packed {
        logic [31:0] normal_sine;
        logic [31:0] normal_cosine;
        logic        saturated;
    } t_gauss_pair;

    // integer square root, bit by bit
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // sqrt(-2 ln(code/2^32)) in Q.20, code nonzero
    function automatic longint unsigned radius_of(input logic [31:0] code);
        int              e;
        longint unsigned mant;
        longint unsigned frac;
        longint unsigned t;
        logic [127:0]    wide;
        e = 31;
        while (code[e] == 1'b0) e--;
        mant = longint'(code) << (31 - e);
        frac = 0;
        for (int i = 0; i < 28; i++) begin
            mant = (mant * mant) >> 31;
            frac = frac << 1;
            if (mant >= (64'd1 << 32)) begin
                frac = frac | 1;
                mant = mant >> 1;
            end
        end
        t = (longint'(32 - e) << 28) - frac;
        wide = 128'(t) * 128'd1488522236;
        return int_sqrt(64'(wide >> 18));
    endfunction

    function automatic logic [31:0] place(input longint unsigned trig, input bit neg,
                                          input bit inf, input longint unsigned r,
                                          input longint mean, input longint unsigned sigma,
                                          inout bit flag);
        longint          v;
        longint unsigned m;
        longint          mag;
        if (inf) begin
            if (trig == 0 || sigma == 0) v = mean;
            else v = neg ? -64'sd2147483648 : 64'sd2147483647;
        end else begin
            m   = (r * trig) >> 30;
            mag = longint'((sigma * m) >> 20);
            v   = mean + (neg ? -mag : mag);
            if (v > 64'sd2147483647) begin v = 64'sd2147483647; flag = 1; end
            if (v < -64'sd2147483648) begin v = -64'sd2147483648; flag = 1; end
        end
        return v[31:0];
    endfunction

    function automatic t_gauss_pair gauss_pair_of(input logic [31:0] c1,
                                                  input logic [31:0] c2,
                                                  input longint mean,
                                                  input longint unsigned sigma);
        t_gauss_pair     p;
        logic [2:0]      oct;
        longint unsigned f, phi, x, z, t, u, sn, cs, sv, cv, r;
        bit              inf, flag;
        oct = c2[31:29];
        f   = c2[28:0];
        phi = oct[0] ? ((64'd1 << 29) - f) : f;
        x   = (phi * 64'd3373259426) >> 31;
        z   = (x * x) >> 30;
        t   = (64'd1 << 30) - z / 42;
        t   = (64'd1 << 30) - ((z * t) >> 30) / 20;
        t   = (64'd1 << 30) - ((z * t) >> 30) / 6;
        sn  = (x * t) >> 30;
        u   = (64'd1 << 30) - z / 56;
        u   = (64'd1 << 30) - ((z * u) >> 30) / 30;
        u   = (64'd1 << 30) - ((z * u) >> 30) / 12;
        cs  = (64'd1 << 30) - ((z * u) >> 30) / 2;
        if (((oct + 3'd1) >> 1) & 1) begin sv = cs; cv = sn; end
        else begin sv = sn; cv = cs; end
        inf  = (c1 == 0);
        flag = inf;
        r    = inf ? 0 : radius_of(c1);
        p.normal_sine   = place(sv, oct >= 4, inf, r, mean, sigma, flag);
        p.normal_cosine = place(cv, ((4'(oct) + 4'd2) >> 2) & 1, inf, r, mean, sigma, flag);
        p.saturated     = flag;
        return p;
    endfunction

endpackage

// ===== tb/box_muller_gaussian_pair_unit_test.sv =====
// Testbench of the Gaussian pair unit: directed corners, then random pairs
// under several mean/spread settings and idle mixes. Depends on bm_pkg, bm_if, bm_tb_pkg.
module box_muller_gaussian_pair_unit_test;
    import bm_pkg::*;
    import bm_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;

    bm_in_if  in_ch();
    bm_out_if out_ch();
    bm_cfg_if cfg_ch();

    box_muller_gaussian_pair_unit i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    // predictor copy of the configuration
    longint          mean_q16;
    longint unsigned sigma_q16;

    t_gauss_pair pending_pairs[$];
    int          error_count;
    longint      cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: slowest run is far below this
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 400000) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // receiver: random stalls plus an optional long hold-off
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                if (pending_pairs.size() == 0) begin
                    report("unexpected word", out_ch.normal_sine, 32'h0);
                end else begin
                    t_gauss_pair want;
                    want = pending_pairs.pop_front();
                    if (out_ch.normal_sine !== want.normal_sine)
                        report("normal_sine", out_ch.normal_sine, want.normal_sine);
                    if (out_ch.normal_cosine !== want.normal_cosine)
                        report("normal_cosine", out_ch.normal_cosine, want.normal_cosine);
                    if (out_ch.saturated !== want.saturated)
                        report("saturated", 32'(out_ch.saturated), 32'(want.saturated));
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // send one word, idle at random first; predict on acceptance
    task automatic send_pair(input logic [31:0] c1, input logic [31:0] c2);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.uniform_radius <= c1;
        in_ch.uniform_angle  <= c2;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_pairs.push_back(gauss_pair_of(c1, c2, mean_q16, sigma_q16));
    endtask

    // drop valid, wait until every result is in, then let the pipe drain
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == CFG_MEAN) mean_q16 = longint'(signed'(value));
        else sigma_q16 = value[30:0];
    endtask

    task automatic set_config(input logic [31:0] mean, input logic [31:0] sigma);
        drain();
        write_reg(CFG_MEAN, mean);
        write_reg(CFG_SPREAD, sigma);
        cfg_ch.valid <= 1'b0;
    endtask

    // corners: zero radius code, top codes, every octant and its boundaries
    task automatic test_directed();
        logic [31:0] angles[10] = '{32'h0, 32'h2000_0000, 32'h4000_0000, 32'h6000_0000,
                                    32'h8000_0000, 32'hA000_0000, 32'hC000_0000,
                                    32'hE000_0000, 32'hFFFF_FFFF, 32'h1FFF_FFFF};
        foreach (angles[k]) send_pair(32'h0, angles[k]);
        send_pair(32'h1, 32'h1234_5678);
        send_pair(32'hFFFF_FFFF, 32'h9000_0000);
        send_pair(32'h8000_0000, 32'h5000_0000);
        send_pair(32'h0000_0001, 32'hFFFF_FFFF);
        for (int k = 0; k < 8; k++) send_pair($urandom, {3'(k), 29'h0AAA_AAAA});
    endtask

    // random pairs; some radius codes tiny so the tail is exercised
    task automatic test_random(input int count);
        logic [31:0] c1;
        for (int k = 0; k < count; k++) begin
            c1 = $urandom;
            case ($urandom_range(9))
                0: c1 = c1 >> $urandom_range(31);
                1: c1 = 32'h0;
                default: ;
            endcase
            send_pair(c1, $urandom);
        end
    endtask

    // stall the receiver for a long stretch while offering words
    task automatic test_backpressure();
        hold_off_cycles = 300;
        send_idle_pct   = 0;
        test_random(150);
    endtask

    initial begin
        error_count     = 0;
        hold_off_cycles = 0;
        send_idle_pct   = 26;
        recv_stall_pct  = 79;
        mean_q16        = 0;
        sigma_q16       = 65536;
        in_ch.valid          <= 1'b0;
        in_ch.uniform_radius <= '0;
        in_ch.uniform_angle  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_MEAN;
        cfg_ch.data  <= '0;
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(400);
        // extreme spreads and means drive saturation
        set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        test_directed();
        test_random(200);
        send_idle_pct  = 79;
        recv_stall_pct = 26;
        set_config(32'h8000_0000, 32'h0);
        test_random(150);
        set_config(32'hFFF0_0000, 32'h0004_0000);
        test_random(300);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_config(32'h0001_8000, 32'h0000_0100);
        test_random(300);
        test_backpressure();
        drain();

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
